@@ hw/rtl/dctd_pkg.sv @@
package dctd_pkg;

    localparam int NUMBER_WIDTH_DEF = 16;
    localparam int COUNT_W          = 8;
    localparam int COUNT_MAX        = 255;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture number, reset working registers
        logic shift2;     // strip one factor two
        logic mul;        // fold the current exponent into the count
        logic mul_two;    // fold a leftover prime into the count
        logic div_start;  // load the divider with rest and candidate
        logic div_step;   // one restoring division step
        logic take_quo;   // rest becomes the quotient, exponent advances
        logic next_cand;  // advance to the next odd candidate
        logic publish;    // move the count into the output register
    } t_dctd_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rest_zero;
        logic rest_odd;
        logic rest_gt1;
        logic div_last;
        logic cand_gt_quo;
        logic rem_zero;
    } t_dctd_sts;

endpackage

@@ hw/rtl/dctd_ifs.sv @@
interface dctd_num_if #(
    parameter int NUMBER_WIDTH = dctd_pkg::NUMBER_WIDTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [NUMBER_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface dctd_cnt_if ();
    import dctd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] divisor_count;

    modport source (output valid, output divisor_count, input ready);
    modport sink   (input valid, input divisor_count, output ready);
endinterface

@@ hw/rtl/dctd_ctrl.sv @@
module dctd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dctd_pkg::t_dctd_cmd o_cmd,
    input  dctd_pkg::t_dctd_sts i_sts
);
    import dctd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TWOS  = 7'b0000010,
        S_START = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_LAST  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_in_run, n_in_run;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_in_run    = r_in_run;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_in_run   = 1'b0;
                    n_state    = S_TWOS;
                end
            end
            S_TWOS: begin
                if (i_sts.rest_zero) begin
                    n_state = S_FIN;
                end else if (!i_sts.rest_odd) begin
                    o_cmd.shift2 = 1'b1;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_START;
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_START;
                if (r_in_run) begin
                    if (i_sts.rem_zero) begin
                        o_cmd.take_quo = 1'b1;
                    end else begin
                        // close the run of this prime
                        o_cmd.mul       = 1'b1;
                        o_cmd.next_cand = 1'b1;
                        n_in_run        = 1'b0;
                    end
                end else if (i_sts.cand_gt_quo) begin
                    // candidate squared exceeds rest
                    n_state = S_LAST;
                end else if (i_sts.rem_zero) begin
                    o_cmd.take_quo = 1'b1;
                    n_in_run       = 1'b1;
                end else begin
                    o_cmd.next_cand = 1'b1;
                end
            end
            S_LAST: begin
                o_cmd.mul_two = i_sts.rest_gt1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_run    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_run    <= n_in_run;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/dctd_dp.sv @@
module dctd_dp #(
    parameter int NUMBER_WIDTH = dctd_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic [NUMBER_WIDTH-1:0]      i_number,
    input  dctd_pkg::t_dctd_cmd          i_cmd,
    output dctd_pkg::t_dctd_sts          o_sts,
    output logic [dctd_pkg::COUNT_W-1:0] o_count
);
    import dctd_pkg::*;

    localparam int W     = NUMBER_WIDTH;
    localparam int EXP_W = $clog2(W + 1);
    localparam int CNT_W = $clog2(W + 1);
    localparam int FAC_W = EXP_W + 1;
    localparam int PRD_W = COUNT_W + FAC_W;

    logic [W-1:0]       r_rest, n_rest;
    logic [W-1:0]       r_cand, n_cand;
    logic [EXP_W-1:0]   r_exp, n_exp;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [W-1:0]       r_quo, n_quo;
    logic [W-1:0]       r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_count;

    logic [W:0]         rem_sh;
    logic               rem_ge;
    logic [W:0]         rem_diff;
    logic [FAC_W-1:0]   factor;
    logic [PRD_W-1:0]   product;

    assign rem_sh   = {r_rem, r_quo[W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_cand});
    assign rem_diff = rem_sh - {1'b0, r_cand};

    assign factor  = i_cmd.mul_two ? FAC_W'(2) : (FAC_W'(r_exp) + FAC_W'(1));
    assign product = PRD_W'(r_total) * PRD_W'(factor);

    always_comb begin
        n_rest  = r_rest;
        n_cand  = r_cand;
        n_exp   = r_exp;
        n_total = r_total;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;

        if (i_cmd.load) begin
            n_rest  = i_number;
            n_cand  = W'(3);
            n_exp   = '0;
            n_total = (i_number == '0) ? COUNT_W'(0) : COUNT_W'(1);
        end
        if (i_cmd.shift2) begin
            n_rest = r_rest >> 1;
            n_exp  = r_exp + EXP_W'(1);
        end
        if (i_cmd.mul || i_cmd.mul_two) begin
            n_total = (product > PRD_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                    : product[COUNT_W-1:0];
            n_exp   = '0;
        end
        if (i_cmd.div_start) begin
            n_quo = r_rest;
            n_rem = '0;
            n_cnt = CNT_W'(W);
        end
        if (i_cmd.div_step) begin
            n_rem = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
            n_quo = {r_quo[W-2:0], rem_ge};
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (i_cmd.take_quo) begin
            n_rest = r_quo;
            n_exp  = r_exp + EXP_W'(1);
        end
        if (i_cmd.next_cand) begin
            n_cand = r_cand + W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_cand  <= n_cand;
        r_exp   <= n_exp;
        r_total <= n_total;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        if (i_cmd.publish) begin
            r_count <= r_total;
        end
    end

    assign o_count           = r_count;
    assign o_sts.rest_zero   = (r_rest == '0);
    assign o_sts.rest_odd    = r_rest[0];
    assign o_sts.rest_gt1    = (r_rest > W'(1));
    assign o_sts.div_last    = (r_cnt == CNT_W'(1));
    assign o_sts.cand_gt_quo = (r_cand > r_quo);
    assign o_sts.rem_zero    = (r_rem == '0);

endmodule

@@ hw/rtl/divisor_count_by_trial_division.sv @@
// Divisor count: takes one unsigned number and returns how many positive
// divisors it has (zero in gives zero out; counts above 255 saturate).
// One number is in work at a time. Factors of two are stripped one at a
// time; after that every trial division runs on a restoring divider
// that retires one quotient bit per cycle. Trial divisions are made by
// odd candidates up to the square root of what remains, plus one per odd
// prime factor found, counted with multiplicity. A finished count waits
// in an output register, and the next number is taken while it waits.
module divisor_count_by_trial_division #(
    parameter int NUMBER_WIDTH = dctd_pkg::NUMBER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dctd_num_if.sink    i_number,
    dctd_cnt_if.source  o_count
);
    import dctd_pkg::*;

    t_dctd_cmd cmd;
    t_dctd_sts sts;

    dctd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_number.valid),
        .o_in_ready  (i_number.ready),
        .o_out_valid (o_count.valid),
        .i_out_ready (o_count.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dctd_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_number (i_number.number),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_count  (o_count.divisor_count)
    );

endmodule
